>>> hw/rtl/cluster_shape_rule_classifier_macros.svh
// assertion helpers for the cluster shape classifier
`ifndef CLUSTER_SHAPE_RULE_CLASSIFIER_MACROS_SVH
`define CLUSTER_SHAPE_RULE_CLASSIFIER_MACROS_SVH

// checked on every clock edge outside reset
`define CSRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define CSRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/csrc_pkg.sv
package csrc_pkg;

  // payload widths fixed by the interface
  localparam int LEN_W   = 16;
  localparam int POS_W   = 18;
  localparam int CNT_W   = 16;
  localparam int Q_W     = 17;
  localparam int DIST_W  = 17;
  localparam int IMP_W   = 4;

  // derived internal widths
  localparam int SQ_W    = 35;   // square of an 18 bit signed value
  localparam int D2_W    = 37;   // sum of three squares
  localparam int DSQ_W   = 34;   // squared distance threshold
  localparam int AREA_W  = 32;
  localparam int VOL_W   = 48;
  localparam int NPROD_W = 41;   // point count times a density bound

  // configuration register indexes
  localparam logic [1:0] REG_MAX_DIST  = 2'd0;
  localparam logic [1:0] REG_FAR_DIST  = 2'd1;
  localparam logic [1:0] REG_PERSON_EN = 2'd2;
  localparam logic [1:0] REG_CAR_EN    = 2'd3;

  // reset thresholds, already squared
  localparam logic [DSQ_W-1:0] MAX_DIST_SQ_RST = 34'd2_500_000_000;
  localparam logic [DSQ_W-1:0] FAR_DIST_SQ_RST = 34'd900_000_000;

  // density bounds, points scaled against volume in mm^3
  localparam logic [NPROD_W-1:0] P_DENS_MAX_VOL = 41'd10_000_000;
  localparam logic [NPROD_W-1:0] P_DENS_MIN_VOL = 41'd20_000;
  localparam logic [NPROD_W-1:0] C_DENS_MAX_VOL = 41'd25_000_000;
  localparam logic [NPROD_W-1:0] C_DENS_MIN_VOL = 41'd40_000;

  localparam logic [IMP_W-1:0] PERSON_IMP_MIN  = 4'd4;
  localparam logic [IMP_W-1:0] CAR_IMP_MIN     = 4'd6;
  localparam logic [IMP_W-1:0] CAR_IMP_MIN_FAR = 4'd7;
  localparam logic [IMP_W-1:0] IMP_MAX         = 4'd10;

  typedef enum logic [1:0] {
    CLASS_NONE   = 2'd0,
    CLASS_PERSON = 2'd1,
    CLASS_CAR    = 2'd2
  } class_t;

  // rule outcomes handed from the compare stage to the decision stage
  typedef struct packed {
    logic [4:0] p_crit;
    logic [5:0] p_imp;
    logic [7:0] c_crit;
    logic [9:0] c_imp;
  } rule_bits_t;

endpackage

>>> hw/rtl/cluster_shape_rule_classifier.sv
// Cluster shape rule classifier. Each input beat carries one cluster's box
// extents, centroid, lowest z, point count, planarity and sphericity; each
// input beat gives exactly one output beat with the class (none, person,
// car), the far flag, whether all critical rules of the last rule set tried
// passed, and how many of its important rules passed. Throughput is one
// cluster per clock when the output side does not stall. Four register
// stages lie between the input beat and the output beat, in order:
// stage one holds the centroid squares and the footprint from the 18x18 and
// 16x16 multipliers, stage two the distance compares, the 32x16 volume
// multiply and the point count products, stage three every rule compare, and
// stage four the rule counts and the class decision (the output register).
// Each stage has its own valid bit and moves whenever the stage after it is
// free, so a stalled result does not block input while earlier stages are
// empty. Configuration writes take effect on the next clock and are meant
// for times with no beat in flight; the distance thresholds are squared at
// write time, so compares run on squared centroid norms.
module cluster_shape_rule_classifier
  import csrc_pkg::*;
#(
  parameter int LEN_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  // configuration
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [DIST_W-1:0]       cfg_data,
  // input channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [LEN_W-1:0]        box_length,
  input  logic [LEN_W-1:0]        box_width,
  input  logic [LEN_W-1:0]        box_height,
  input  logic signed [POS_W-1:0] center_x,
  input  logic signed [POS_W-1:0] center_y,
  input  logic signed [POS_W-1:0] center_z,
  input  logic signed [POS_W-1:0] lowest_z,
  input  logic [CNT_W-1:0]        point_count,
  input  logic [Q_W-1:0]          planarity,
  input  logic [Q_W-1:0]          sphericity,
  // output channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              class_code,
  output logic                    far_flag,
  output logic                    critical_ok,
  output logic [IMP_W-1:0]        important_passed
);

`include "cluster_shape_rule_classifier_macros.svh"

  // extents keep only their low LEN_BITS bits
  localparam int LW = (LEN_BITS < LEN_W) ? LEN_BITS : LEN_W;

  // ---------------------------------------------------------------------
  // configuration registers, thresholds stored squared
  // ---------------------------------------------------------------------
  logic [DSQ_W-1:0] max_sq;
  logic [DSQ_W-1:0] far_sq;
  logic             person_en;
  logic             car_en;
  logic [DSQ_W-1:0] cfg_sq;

  assign cfg_sq = DSQ_W'(cfg_data) * DSQ_W'(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_sq    <= MAX_DIST_SQ_RST;
      far_sq    <= FAR_DIST_SQ_RST;
      person_en <= 1'b1;
      car_en    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_DIST:  max_sq    <= cfg_sq;
        REG_FAR_DIST:  far_sq    <= cfg_sq;
        REG_PERSON_EN: person_en <= cfg_data[0];
        REG_CAR_EN:    car_en    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // stage handshake: a stage loads when it is empty or its content moves on
  // ---------------------------------------------------------------------
  logic v1, v2, v3, v4;
  logic go1, go2, go3, go4;

  assign go4      = !v4 || out_ready;
  assign go3      = !v3 || go4;
  assign go2      = !v2 || go3;
  assign go1      = !v1 || go2;
  assign in_ready = go1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (go1) v1 <= in_valid;
      if (go2) v2 <= v1;
      if (go3) v3 <= v2;
      if (go4) v4 <= v3;
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: centroid squares and footprint
  // ---------------------------------------------------------------------
  logic [LEN_W-1:0]          l_in, w_in, h_in;
  logic signed [2*POS_W-1:0] prod_x, prod_y, prod_z;

  assign l_in   = LEN_W'(box_length[LW-1:0]);
  assign w_in   = LEN_W'(box_width[LW-1:0]);
  assign h_in   = LEN_W'(box_height[LW-1:0]);
  assign prod_x = center_x * center_x;
  assign prod_y = center_y * center_y;
  assign prod_z = center_z * center_z;

  logic [SQ_W-1:0]          s1_sqx, s1_sqy, s1_sqz;
  logic [AREA_W-1:0]        s1_area;
  logic [LEN_W-1:0]         s1_l, s1_w, s1_h;
  logic signed [POS_W-1:0]  s1_cz, s1_bz;
  logic [CNT_W-1:0]         s1_n;
  logic [Q_W-1:0]           s1_pl, s1_sp;

  always_ff @(posedge clk) begin
    if (go1) begin
      s1_sqx  <= prod_x[SQ_W-1:0];
      s1_sqy  <= prod_y[SQ_W-1:0];
      s1_sqz  <= prod_z[SQ_W-1:0];
      s1_area <= AREA_W'(l_in) * AREA_W'(w_in);
      s1_l    <= l_in;
      s1_w    <= w_in;
      s1_h    <= h_in;
      s1_cz   <= center_z;
      s1_bz   <= lowest_z;
      s1_n    <= point_count;
      s1_pl   <= planarity;
      s1_sp   <= sphericity;
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: distance compares, volume, density products, extent order
  // ---------------------------------------------------------------------
  logic [D2_W-1:0] d2;

  assign d2 = D2_W'(s1_sqx) + D2_W'(s1_sqy) + D2_W'(s1_sqz);

  logic                     s2_far, s2_near, s2_nz;
  logic [VOL_W-1:0]         s2_vol;
  logic [NPROD_W-1:0]       s2_pd_hi, s2_pd_lo, s2_cd_hi, s2_cd_lo;
  logic [AREA_W-1:0]        s2_area;
  logic [LEN_W-1:0]         s2_l, s2_w, s2_h, s2_mx, s2_mn;
  logic signed [POS_W-1:0]  s2_cz, s2_bz;
  logic [CNT_W-1:0]         s2_n;
  logic [Q_W-1:0]           s2_pl, s2_sp;

  always_ff @(posedge clk) begin
    if (go2) begin
      s2_far   <= d2 > D2_W'(far_sq);
      s2_near  <= d2 <= D2_W'(max_sq);
      s2_nz    <= s1_n != '0;
      s2_vol   <= VOL_W'(s1_area) * VOL_W'(s1_h);
      s2_pd_hi <= NPROD_W'(s1_n) * P_DENS_MAX_VOL;
      s2_pd_lo <= NPROD_W'(s1_n) * P_DENS_MIN_VOL;
      s2_cd_hi <= NPROD_W'(s1_n) * C_DENS_MAX_VOL;
      s2_cd_lo <= NPROD_W'(s1_n) * C_DENS_MIN_VOL;
      s2_area  <= s1_area;
      s2_l     <= s1_l;
      s2_w     <= s1_w;
      s2_h     <= s1_h;
      s2_mx    <= (s1_l > s1_w) ? s1_l : s1_w;
      s2_mn    <= (s1_l > s1_w) ? s1_w : s1_l;
      s2_cz    <= s1_cz;
      s2_bz    <= s1_bz;
      s2_n     <= s1_n;
      s2_pl    <= s1_pl;
      s2_sp    <= s1_sp;
    end
  end

  // ---------------------------------------------------------------------
  // stage 3: every rule compare
  // ---------------------------------------------------------------------
  rule_bits_t       rules;
  logic [LEN_W:0]   sum_lw;
  logic [VOL_W-1:0] vol_pd_hi, vol_pd_lo, vol_cd_hi, vol_cd_lo;

  assign sum_lw    = (LEN_W+1)'(s2_l) + (LEN_W+1)'(s2_w);
  assign vol_pd_hi = VOL_W'(s2_pd_hi);
  assign vol_pd_lo = VOL_W'(s2_pd_lo);
  assign vol_cd_hi = VOL_W'(s2_cd_hi);
  assign vol_cd_lo = VOL_W'(s2_cd_lo);

  always_comb begin
    // person critical rules: height band, tallest extent, slender, narrow, small footprint
    rules.p_crit[0] = s2_h >= 16'd1300 && s2_h <= 16'd2200;
    rules.p_crit[1] = s2_h >= s2_l && s2_h >= s2_w;
    rules.p_crit[2] = sum_lw != '0 && 21'(s2_h) * 21'd20 >= 21'(sum_lw) * 21'd13;
    rules.p_crit[3] = s2_mx <= (s2_far ? 16'd765 : 16'd850);
    rules.p_crit[4] = s2_area <= (s2_far ? 32'd540_000 : 32'd600_000);
    // person important rules
    rules.p_imp[0]  = s2_cz >= 18'sd500 && s2_cz <= 18'sd2000;
    rules.p_imp[1]  = s2_vol >= 48'd100_000_000 && s2_vol <= 48'd5_000_000_000;
    rules.p_imp[2]  = s2_n >= 16'd30 && s2_n <= 16'd2000;
    rules.p_imp[3]  = s2_vol != '0 && vol_pd_hi >= s2_vol && vol_pd_lo <= s2_vol;
    rules.p_imp[4]  = 21'(s2_pl) * 21'd10 < 21'd458_752 && 20'(s2_sp) * 20'd5 > 20'd65_536;
    rules.p_imp[5]  = s2_mn != '0 && 20'(s2_mx) * 20'd5 <= 20'(s2_mn) * 20'd11;
    // car critical rules
    rules.c_crit[0] = s2_h >= 16'd1000 && s2_h <= 16'd2200;
    rules.c_crit[1] = s2_l >= s2_w && s2_l >= s2_h;
    rules.c_crit[2] = s2_l >= 16'd2800;
    rules.c_crit[3] = s2_w != '0 && 19'(s2_l) * 19'd5 >= 19'(s2_w) * 19'd8;
    rules.c_crit[4] = s2_far ? (s2_area >= 32'd4_500_000 && s2_area <= 32'd14_000_000)
                             : (s2_area >= 32'd3_500_000 && s2_area <= 32'd16_000_000);
    rules.c_crit[5] = s2_w >= 16'd1500 && s2_w <= 16'd2400;
    rules.c_crit[6] = s2_bz <= 18'sd300;
    rules.c_crit[7] = s2_l < 16'd7000 && !(s2_w >= 16'd1800 && s2_area >= 32'd12_000_000);
    // car important rules
    rules.c_imp[0]  = s2_cz >= 18'sd200 && s2_cz <= 18'sd1200;
    rules.c_imp[1]  = s2_vol >= 48'd2_000_000_000 && s2_vol <= 48'd55_000_000_000;
    rules.c_imp[2]  = s2_l < 16'd7000;
    rules.c_imp[3]  = s2_n >= 16'd250 && s2_n <= 16'd18000;
    rules.c_imp[4]  = s2_vol != '0 && s2_vol <= vol_cd_hi && vol_cd_lo <= s2_vol;
    rules.c_imp[5]  = s2_l == '0 || 21'(s2_h) * 21'd20 <= 21'(s2_l) * 21'd13;
    rules.c_imp[6]  = 20'(s2_pl) * 20'd5 > 20'd65_536;
    rules.c_imp[7]  = s2_w != '0 && 18'(s2_h) * 18'd2 <= 18'(s2_w) * 18'd3;
    // volume over footprint is the height itself
    rules.c_imp[8]  = s2_area != '0 && s2_h >= 16'd700 && s2_h <= 16'd2500;
    rules.c_imp[9]  = s2_h <= 16'd2200;
  end

  rule_bits_t s3_rules;
  logic       s3_far, s3_near, s3_nz;

  always_ff @(posedge clk) begin
    if (go3) begin
      s3_rules <= rules;
      s3_far   <= s2_far;
      s3_near  <= s2_near;
      s3_nz    <= s2_nz;
    end
  end

  // ---------------------------------------------------------------------
  // stage 4: rule counts and class decision into the output register
  // ---------------------------------------------------------------------
  logic [IMP_W-1:0] p_cnt, c_cnt;

  always_comb begin
    p_cnt = '0;
    for (int i = 0; i < 6; i++) begin
      p_cnt = p_cnt + IMP_W'(s3_rules.p_imp[i]);
    end
  end

  always_comb begin
    c_cnt = '0;
    for (int i = 0; i < 10; i++) begin
      c_cnt = c_cnt + IMP_W'(s3_rules.c_imp[i]);
    end
  end

  class_t           cls_next;
  logic             far_next, crit_next;
  logic [IMP_W-1:0] imp_next;

  always_comb begin
    logic person_hit;
    person_hit = 1'b0;
    cls_next   = CLASS_NONE;
    crit_next  = 1'b0;
    imp_next   = '0;
    // an empty cluster reports nothing, not even the far flag
    far_next   = s3_nz && s3_far;
    if (s3_nz && s3_near) begin
      if (person_en) begin
        crit_next  = &s3_rules.p_crit;
        imp_next   = p_cnt;
        person_hit = crit_next && p_cnt >= PERSON_IMP_MIN;
        if (person_hit) cls_next = CLASS_PERSON;
      end
      // car rules are tried only when no person was found
      if (!person_hit && car_en) begin
        crit_next = &s3_rules.c_crit;
        imp_next  = c_cnt;
        if (crit_next && c_cnt >= (s3_far ? CAR_IMP_MIN_FAR : CAR_IMP_MIN)) begin
          cls_next = CLASS_CAR;
        end
      end
    end
  end

  class_t           cls;
  logic             far_q, crit_q;
  logic [IMP_W-1:0] imp_q;

  always_ff @(posedge clk) begin
    if (go4) begin
      cls    <= cls_next;
      far_q  <= far_next;
      crit_q <= crit_next;
      imp_q  <= imp_next;
    end
  end

  assign out_valid        = v4;
  assign class_code       = cls;
  assign far_flag         = far_q;
  assign critical_ok      = crit_q;
  assign important_passed = imp_q;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  `CSRC_ASSERT(a_person_rules,
    (out_valid && class_code == CLASS_PERSON)
      |-> (critical_ok && important_passed >= PERSON_IMP_MIN),
    "person reported without its rules passing")
  `CSRC_ASSERT(a_car_rules,
    (out_valid && class_code == CLASS_CAR)
      |-> (critical_ok && important_passed >= CAR_IMP_MIN),
    "car reported without its rules passing")
  `CSRC_ASSERT(a_empty_pipe_latency,
    (in_valid && in_ready && !v1 && !v2 && !v3 && !v4) |-> ##4 out_valid,
    "beat into an empty pipeline did not reach the output in four cycles")
  `CSRC_ASSERT(a_count_range,
    out_valid |-> (important_passed <= IMP_MAX),
    "important rule count out of range")

endmodule

>>> tb/sv/tb_cluster_shape_rule_classifier.sv
`timescale 1ns / 100ps

module tb_cluster_shape_rule_classifier;
  import csrc_pkg::*;

  // watchdog: cycles with no beat on either channel before the run is abandoned
  localparam int IDLE_LIMIT = 2000;
  // pause after the last result, longer than the four stage pipeline
  localparam int DRAIN_CYCLES = 8;

  // one cluster as it goes into the block
  typedef struct {
    logic [LEN_W-1:0]        length;
    logic [LEN_W-1:0]        width;
    logic [LEN_W-1:0]        height;
    logic signed [POS_W-1:0] cx;
    logic signed [POS_W-1:0] cy;
    logic signed [POS_W-1:0] cz;
    logic signed [POS_W-1:0] bz;
    logic [CNT_W-1:0]        points;
    logic [Q_W-1:0]          planar;
    logic [Q_W-1:0]          spheric;
  } cluster_t;

  // one labelled cluster as it comes out
  typedef struct {
    class_t           cls;
    logic             far;
    logic             crit;
    logic [IMP_W-1:0] imp;
  } verdict_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  logic [1:0]              cfg_index;
  logic [DIST_W-1:0]       cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic [LEN_W-1:0]        box_length;
  logic [LEN_W-1:0]        box_width;
  logic [LEN_W-1:0]        box_height;
  logic signed [POS_W-1:0] center_x;
  logic signed [POS_W-1:0] center_y;
  logic signed [POS_W-1:0] center_z;
  logic signed [POS_W-1:0] lowest_z;
  logic [CNT_W-1:0]        point_count;
  logic [Q_W-1:0]          planarity;
  logic [Q_W-1:0]          sphericity;
  logic                    out_valid;
  logic                    out_ready;
  logic [1:0]              class_code;
  logic                    far_flag;
  logic                    critical_ok;
  logic [IMP_W-1:0]        important_passed;

  // shadow copy of the classifier registers, kept in step with every write
  logic [DIST_W-1:0] max_dist_mm;
  logic [DIST_W-1:0] far_dist_mm;
  logic              person_on;
  logic              car_on;

  // labels still owed by the block, oldest first
  verdict_t pending_verdicts[$];

  // when set, neither side inserts gaps or stalls
  bit steady;

  int n_sent;
  int n_checked;
  int n_errors;
  int n_settings;
  int n_person;
  int n_car;
  int n_none;

  cluster_shape_rule_classifier i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .box_length       (box_length),
    .box_width        (box_width),
    .box_height       (box_height),
    .center_x         (center_x),
    .center_y         (center_y),
    .center_z         (center_z),
    .lowest_z         (lowest_z),
    .point_count      (point_count),
    .planarity        (planarity),
    .sphericity       (sphericity),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .class_code       (class_code),
    .far_flag         (far_flag),
    .critical_ok      (critical_ok),
    .important_passed (important_passed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // expected label for one cluster under the current register copy;
  // every rule is an exact integer compare, ratios by cross-multiplication
  function automatic verdict_t classify_cluster(cluster_t c);
    longint l, w, h, cx, cy, cz, bz, n, pl, sp;
    longint d2, area, vol, mx, mn;
    int     k;
    bit     far, person;
    verdict_t v;
    v.cls  = CLASS_NONE;
    v.far  = 1'b0;
    v.crit = 1'b0;
    v.imp  = '0;
    l  = longint'(c.length);
    w  = longint'(c.width);
    h  = longint'(c.height);
    cx = longint'(c.cx);
    cy = longint'(c.cy);
    cz = longint'(c.cz);
    bz = longint'(c.bz);
    n  = longint'(c.points);
    pl = longint'(c.planar);
    sp = longint'(c.spheric);
    // empty cluster reports nothing at all, not even the far flag
    if (n == 0) return v;

    // squared norm against squared thresholds
    d2  = cx * cx + cy * cy + cz * cz;
    far = d2 > longint'(far_dist_mm) * longint'(far_dist_mm);
    v.far = far;
    if (d2 > longint'(max_dist_mm) * longint'(max_dist_mm)) return v;

    area   = l * w;
    vol    = area * h;
    mx     = (l > w) ? l : w;
    mn     = (l > w) ? w : l;
    person = 1'b0;

    if (person_on) begin
      k = 0;
      k += (cz >= 500 && cz <= 2000);
      k += (vol >= 100_000_000 && vol <= 64'd5_000_000_000);
      k += (n >= 30 && n <= 2000);
      k += (vol > 0 && n * 10_000_000 >= vol && n * 20_000 <= vol);
      k += (pl * 10 < 7 * 65536 && sp * 5 > 65536);
      k += (mn > 0 && 5 * mx <= 11 * mn);
      // far clusters get the narrower width and footprint limits
      v.crit = (h >= 1300 && h <= 2200) && (h >= l && h >= w) &&
               (l + w > 0 && 20 * h >= 13 * (l + w)) &&
               (mx <= (far ? 765 : 850)) && (area <= (far ? 540_000 : 600_000));
      v.imp  = IMP_W'(k);
      person = v.crit && k >= 4;
      if (person) v.cls = CLASS_PERSON;
    end

    if (!person && car_on) begin
      k = 0;
      k += (cz >= 200 && cz <= 1200);
      k += (vol >= 2_000_000_000 && vol <= 64'd55_000_000_000);
      k += (l < 7000);
      k += (n >= 250 && n <= 18_000);
      k += (vol > 0 && vol <= n * 25_000_000 && n * 40_000 <= vol);
      k += (l == 0 || 20 * h <= 13 * l);
      k += (pl * 5 > 65536);
      k += (w > 0 && 2 * h <= 3 * w);
      k += (area > 0 && h >= 700 && h <= 2500);
      k += (h <= 2200);
      v.crit = (h >= 1000 && h <= 2200) && (l >= w && l >= h) && (l >= 2800) &&
               (w > 0 && 5 * l >= 8 * w) &&
               (far ? (area >= 4_500_000 && area <= 14_000_000)
                    : (area >= 3_500_000 && area <= 16_000_000)) &&
               (w >= 1500 && w <= 2400) && (bz <= 300) &&
               (l < 7000) && !(w >= 1800 && area >= 12_000_000);
      v.imp  = IMP_W'(k);
      // far cars need one more important rule
      if (v.crit && k >= (far ? 7 : 6)) v.cls = CLASS_CAR;
    end
    return v;
  endfunction

  function automatic cluster_t make_cluster(int l, int w, int h, int cx, int cy, int cz,
                                            int bz, int n, int pl, int sp);
    cluster_t c;
    c.length  = LEN_W'(l);
    c.width   = LEN_W'(w);
    c.height  = LEN_W'(h);
    c.cx      = POS_W'(cx);
    c.cy      = POS_W'(cy);
    c.cz      = POS_W'(cz);
    c.bz      = POS_W'(bz);
    c.points  = CNT_W'(n);
    c.planar  = Q_W'(pl);
    c.spheric = Q_W'(sp);
    return c;
  endfunction

  function automatic int near(int centre, int span);
    return centre - span + int'($urandom_range(0, 2 * span));
  endfunction

  function automatic logic [LEN_W-1:0] len_of(int v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return v[LEN_W-1:0];
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // random cluster: some pure noise, the rest shaped like a person or a car
  // with features spread across the rule thresholds
  function automatic cluster_t rand_cluster();
    cluster_t c;
    int reach, kind;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      c.length  = LEN_W'($urandom);
      c.width   = LEN_W'($urandom);
      c.height  = LEN_W'($urandom);
      c.cx      = POS_W'($urandom);
      c.cy      = POS_W'($urandom);
      c.cz      = POS_W'($urandom);
      c.bz      = POS_W'($urandom);
      c.points  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
      c.planar  = Q_W'($urandom);
      c.spheric = Q_W'($urandom);
      return c;
    end
    // centroid reach spans the near, far and beyond-maximum zones
    case ($urandom_range(0, 5))
      0:       reach = 0;
      1:       reach = 4000;
      2:       reach = 20_000;
      3:       reach = 34_000;
      4:       reach = 52_000;
      default: reach = 131_071;
    endcase
    c.cx      = POS_W'(near(0, reach));
    c.cy      = POS_W'(near(0, reach / 4));
    c.planar  = Q_W'($urandom_range(0, 65536));
    c.spheric = Q_W'($urandom_range(0, 65536));
    if (kind < 6) begin
      c.length = len_of(near(550, 450));
      c.width  = len_of(near(500, 400));
      c.height = len_of(near(1750, 600));
      c.cz     = POS_W'(near(1200, 1000));
      c.bz     = POS_W'(near(0, 500));
      c.points = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 40))
                                             : CNT_W'($urandom_range(20, 2500));
    end else begin
      c.length = len_of(near(4800, 2500));
      c.width  = len_of(near(1900, 700));
      c.height = len_of(near(1500, 900));
      c.cz     = POS_W'(near(700, 700));
      c.bz     = POS_W'(near(250, 150));
      c.points = CNT_W'($urandom_range(0, 20_000));
    end
    // a centroid right at the origin is the only one a zero maximum lets through
    if ($urandom_range(0, 7) == 0) begin
      c.cx = '0;
      c.cy = '0;
      c.cz = '0;
    end
    return c;
  endfunction

  // drive one cluster from a falling edge and hold it until the beat is taken;
  // returns at the falling edge after the beat with valid still high
  task automatic send_cluster(cluster_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    box_length  = c.length;
    box_width   = c.width;
    box_height  = c.height;
    center_x    = c.cx;
    center_y    = c.cy;
    center_z    = c.cz;
    lowest_z    = c.bz;
    point_count = c.points;
    planarity   = c.planar;
    sphericity  = c.spheric;
    in_valid    = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_verdicts.insert(pending_verdicts.size(), classify_cluster(c));
    n_sent++;
    @(negedge clk);
  endtask

  // every cluster gives one label, so an empty queue means the pipe is empty
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [DIST_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_MAX_DIST:  max_dist_mm = data;
      REG_FAR_DIST:  far_dist_mm = data;
      REG_PERSON_EN: person_on   = data[0];
      REG_CAR_EN:    car_on      = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [DIST_W-1:0] max_mm, logic [DIST_W-1:0] far_mm,
                               logic p_en, logic c_en);
    wait_drained();
    write_reg(REG_MAX_DIST, max_mm);
    write_reg(REG_FAR_DIST, far_mm);
    // upper data bits set too, only bit zero counts for the enables
    write_reg(REG_PERSON_EN, {16'($urandom), p_en});
    write_reg(REG_CAR_EN, {16'($urandom), c_en});
    n_settings++;
  endtask

  task automatic send_random(int count);
    repeat (count) send_cluster(rand_cluster());
  endtask

  // reset register values: empty clusters, field extremes, distance edges,
  // near and far variants of both classes and the zero-divisor cases
  task automatic test_directed_clusters();
    send_cluster(make_cluster(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_cluster(make_cluster(500, 400, 1700, 3000, 0, 1000, 0, 0, 10000, 20000));
    send_cluster(make_cluster(65535, 65535, 65535, 131071, 131071, 131071, 131071,
                              65535, 131071, 131071));
    send_cluster(make_cluster(0, 0, 0, -131072, -131072, -131072, -131072, 1, 0, 0));
    send_cluster(make_cluster(500, 400, 1700, 3000, 0, 1000, 0, 500, 10000, 20000));
    // exactly on and just past the maximum and far radii
    send_cluster(make_cluster(500, 400, 1700, 50000, 0, 0, 0, 500, 10000, 20000));
    send_cluster(make_cluster(500, 400, 1700, 50001, 0, 0, 0, 500, 10000, 20000));
    send_cluster(make_cluster(500, 400, 1700, 30000, 0, 0, 0, 500, 10000, 20000));
    send_cluster(make_cluster(500, 400, 1700, 30001, 0, 0, 0, 500, 10000, 20000));
    // far person: 800 mm wide fails the tighter limit, 700 mm passes
    send_cluster(make_cluster(800, 400, 1700, 35000, 0, 1000, 0, 500, 10000, 20000));
    send_cluster(make_cluster(700, 400, 1700, 35000, 0, 1000, 0, 500, 10000, 20000));
    send_cluster(make_cluster(4500, 1800, 1500, 5000, 0, 700, 0, 2000, 20000, 0));
    send_cluster(make_cluster(4500, 1800, 1500, 40000, 0, 700, 0, 2000, 20000, 0));
    // zero width, zero length, zero height
    send_cluster(make_cluster(4500, 0, 1500, 5000, 0, 700, 0, 2000, 20000, 0));
    send_cluster(make_cluster(0, 400, 1700, 3000, 0, 1000, 0, 500, 10000, 20000));
    send_cluster(make_cluster(4500, 1800, 0, 5000, 0, 700, 0, 2000, 20000, 0));
    // shape measures at one
    send_cluster(make_cluster(500, 400, 1700, 3000, 0, 1000, 0, 500, 65536, 65536));
    // car bottom z at the limit, one past it, and far below
    send_cluster(make_cluster(4500, 1800, 1500, 5000, 0, 700, 300, 2000, 20000, 0));
    send_cluster(make_cluster(4500, 1800, 1500, 5000, 0, 700, 301, 2000, 20000, 0));
    send_cluster(make_cluster(4500, 1800, 1500, 5000, 0, 700, -131072, 2000, 20000, 0));
    // person height edges
    send_cluster(make_cluster(500, 400, 1300, 3000, 0, 1000, 0, 500, 10000, 20000));
    send_cluster(make_cluster(500, 400, 2200, 3000, 0, 1000, 0, 500, 10000, 20000));
    // car length limit and the wide large footprint exclusion
    send_cluster(make_cluster(7000, 2000, 1500, 5000, 0, 700, 0, 5000, 20000, 0));
    send_cluster(make_cluster(6999, 2000, 1500, 5000, 0, 700, 0, 5000, 20000, 0));
    send_cluster(make_cluster(5000, 2400, 1500, 5000, 0, 700, 0, 5000, 20000, 0));
  endtask

  // distance radii at their extremes and every enable combination
  task automatic test_register_sweep();
    logic [DIST_W-1:0] max_list [7] = '{0, 131071, 131071, 50000, 50000, 50000, 20000};
    logic [DIST_W-1:0] far_list [7] = '{0, 131071, 0, 30000, 30000, 30000, 10000};
    logic              pen_list [7] = '{1, 1, 1, 0, 1, 0, 1};
    logic              cen_list [7] = '{1, 1, 1, 1, 0, 0, 1};
    for (int i = 0; i < 7; i++) begin
      apply_setting(max_list[i], far_list[i], pen_list[i], cen_list[i]);
      send_random(45);
    end
  endtask

  // full rate on both sides at the reset register values
  task automatic test_back_to_back();
    apply_setting(50000, 30000, 1'b1, 1'b1);
    steady = 1'b1;
    send_random(120);
    steady = 1'b0;
  endtask

  // long stretch with random gaps and stalls
  task automatic test_random_traffic();
    send_random(300);
  endtask

  // output side: ready mostly high, short stalls often, long ones rarely
  initial begin : sink_stall
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && !steady && $urandom_range(0, 99) < 25)
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                : $urandom_range(1, 3);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // compare each output beat with the oldest outstanding label
  always @(posedge clk) begin : label_check
    verdict_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        if (n_errors < 10)
          $display("unexpected output beat: class %0d far %0b crit %0b imp %0d",
                   class_code, far_flag, critical_ok, important_passed);
        n_errors++;
      end else begin
        want = pending_verdicts.pop_front();
        n_checked++;
        case (want.cls)
          CLASS_PERSON: n_person++;
          CLASS_CAR:    n_car++;
          default:      n_none++;
        endcase
        if (class_code !== want.cls || far_flag !== want.far ||
            critical_ok !== want.crit || important_passed !== want.imp) begin
          if (n_errors < 10) begin
            $display("mismatch on label %0d: expected class %0d far %0b crit %0b imp %0d",
                     n_checked, want.cls, want.far, want.crit, want.imp);
            $display("  got class %0d far %0b crit %0b imp %0d",
                     class_code, far_flag, critical_ok, important_passed);
          end
          n_errors++;
        end
      end
    end
  end

  // abandon the run once neither channel has moved for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
    $display("cluster_shape_rule_classifier test failed");
    $finish;
  end

  initial begin
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = REG_MAX_DIST;
    cfg_data    = '0;
    in_valid    = 1'b0;
    box_length  = '0;
    box_width   = '0;
    box_height  = '0;
    center_x    = '0;
    center_y    = '0;
    center_z    = '0;
    lowest_z    = '0;
    point_count = '0;
    planarity   = '0;
    sphericity  = '0;
    // register copy starts at the reset values
    max_dist_mm = 17'd50000;
    far_dist_mm = 17'd30000;
    person_on   = 1'b1;
    car_on      = 1'b1;
    steady      = 1'b0;
    n_sent      = 0;
    n_checked   = 0;
    n_errors    = 0;
    n_settings  = 1;
    n_person    = 0;
    n_car       = 0;
    n_none      = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_clusters();
    test_register_sweep();
    test_back_to_back();
    test_random_traffic();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d of %0d clusters under %0d register settings",
             n_checked, n_sent, n_settings);
    $display("labels seen: %0d person, %0d car, %0d none, %0d errors",
             n_person, n_car, n_none, n_errors);
    if (n_errors == 0 && pending_verdicts.size() == 0)
      $display("cluster_shape_rule_classifier test passed");
    else
      $display("cluster_shape_rule_classifier test failed");
    $finish;
  end

endmodule
